// ----- hdl/cwg_pkg.sv -----
package cwg_pkg;

	localparam int INST_W   = 3;
	localparam int PHASE_W  = 32;
	localparam int SAMPLE_W = 17;

	typedef enum logic [INST_W-1:0] {
		WAVE_TRIANGLE = 3'd0,
		WAVE_TILT_SAW = 3'd1,
		WAVE_SAW      = 3'd2,
		WAVE_SQUARE   = 3'd3,
		WAVE_PULSE    = 3'd4,
		WAVE_ORGAN    = 3'd5,
		WAVE_NOISE    = 3'd6,
		WAVE_PHASER   = 3'd7
	} inst_t;

	// How the last stage forms the sample from the quotient or the direct value.
	typedef enum logic [1:0] {
		KIND_DIRECT,
		KIND_TILT,
		KIND_SIGNED
	} kind_t;

	// Which constant the shared multiplier scales by.
	typedef enum logic [2:0] {
		DIV_KNEE,
		DIV_KNEE_C,
		DIV_NINE,
		DIV_SIX,
		DIV_SAW
	} div_t;

	typedef struct packed {
		kind_t kind;
		div_t  sel;
		logic  neg;
	} ctrl_t;

endpackage

// ----- hdl/chiptune_waveform_generator.sv -----
// Chiptune oscillator: one audio sample per input beat.
// The item channel (item_valid/item_ready) carries an instrument number and a
// signed fixed-point phase; the sample channel (sample_valid/sample_ready)
// returns one signed fixed-point sample for each accepted beat, in order.
// Seven waveshapes are formed from the fractional part of the phase (the phaser's
// modulator also reads higher phase bits); the noise instrument returns zero.
// The block is a four-register pipeline: input register, shaping, a multiply
// by a constant reciprocal, and a correction step that feeds the output
// register. One beat can be taken every cycle, since every stage moves on
// each cycle unless the receiver stalls.
// Each stage moves forward whenever it is empty or the stage after it moves,
// so bubbles close up while the receiver stalls and new beats keep entering
// until all four registers are full. A held sample stays stable until taken.
// Reset empties the pipeline: sample_valid drops and item_ready rises.
module chiptune_waveform_generator
	import cwg_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [INST_W-1:0]           instrument,
	input  logic signed [PHASE_W-1:0]   phase,
	output logic                        sample_valid,
	input  logic                        sample_ready,
	output logic signed [SAMPLE_W-1:0]  sample
);

	localparam int F = FRAC_BITS;

	logic                      valid_s1;
	logic                      valid_s2;
	logic                      valid_s3;
	logic                      valid_s4;
	logic                      en_s1;
	logic                      en_s2;
	logic                      en_s3;
	logic                      en_s4;
	logic [INST_W-1:0]         instrument_s1;
	logic signed [PHASE_W-1:0] phase_s1;
	ctrl_t                     ctrl_d;
	logic [F+2:0]              n_d;
	logic signed [F+3:0]       direct_d;
	ctrl_t                     ctrl_s2;
	logic [F+2:0]              n_s2;
	logic signed [F+3:0]       direct_s2;

	assign en_s4 = !valid_s4 || sample_ready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign item_ready   = en_s1;
	assign sample_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= item_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			instrument_s1 <= instrument;
			phase_s1      <= phase;
		end
	end

	cwg_shape #(
		.FRAC_BITS (FRAC_BITS)
	) u_shape (
		.instrument (instrument_s1),
		.phase      (phase_s1),
		.ctrl       (ctrl_d),
		.n          (n_d),
		.direct     (direct_d)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctrl_s2   <= ctrl_d;
			n_s2      <= n_d;
			direct_s2 <= direct_d;
		end
	end

	cwg_divide #(
		.FRAC_BITS (FRAC_BITS)
	) u_divide (
		.clk       (clk),
		.en_s3     (en_s3),
		.en_s4     (en_s4),
		.ctrl_s2   (ctrl_s2),
		.n_s2      (n_s2),
		.direct_s2 (direct_s2),
		.sample    (sample)
	);

endmodule

// ----- hdl/cwg_shape.sv -----
module cwg_shape
	import cwg_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic [INST_W-1:0]         instrument,
	input  logic signed [PHASE_W-1:0] phase,
	output ctrl_t                     ctrl,
	output logic [FRAC_BITS+2:0]      n,
	output logic signed [FRAC_BITS+3:0] direct
);

	localparam int F  = FRAC_BITS;
	localparam int W  = F + 6;
	localparam int NW = F + 3;
	localparam int VW = F + 4;
	localparam logic [63:0] ONE64   = 64'd1 << F;
	localparam logic [63:0] KNEE64  = (64'd9 << F) / 64'd10;
	localparam logic [63:0] THIRD64 = (64'd3333 << F) / 64'd10000;

	function automatic logic signed [W-1:0] sabs(input logic signed [W-1:0] v);
		return (v < 0) ? -v : v;
	endfunction

	logic [F-1:0]          t;
	logic [F-1:0]          f;
	logic [F-1:0]          hk;
	logic [F-1:0]          u;
	logic signed [W-1:0]   ts;
	logic signed [W-1:0]   fs;
	logic signed [W-1:0]   us;
	logic signed [W-1:0]   one_s;
	logic signed [W-1:0]   tri_r;
	logic signed [W-1:0]   org_r;
	logic signed [W-1:0]   ph_k;
	logic signed [W-1:0]   ph_r;
	logic signed [VW-1:0]  quart_v;

	assign t     = phase[F-1:0];
	assign f     = phase[F+6:7];
	assign ts    = $signed({6'b0, t});
	assign fs    = $signed({6'b0, f});
	assign one_s = $signed(W'(ONE64));
	assign quart_v = $signed(VW'(ONE64 >> 2));

	assign tri_r = (sabs((ts <<< 2) - (one_s <<< 1)) - one_s) >>> 1;

	always_comb begin
		if (!t[F-1]) begin
			org_r = (one_s * W'(3))
				- sabs((ts <<< 4) + (ts <<< 3) - (one_s <<< 2) - (one_s <<< 1));
		end else begin
			org_r = one_s - sabs((ts <<< 4) - (one_s <<< 3) - (one_s <<< 2));
		end
	end

	// The phaser shifts the carrier by half of a slow triangle, wrapping within one period.
	assign ph_k = sabs((fs <<< 1) - one_s);
	assign hk   = ph_k[F:1];
	assign u    = t + hk;
	assign us   = $signed({6'b0, u});
	assign ph_r = sabs((us <<< 2) - (one_s <<< 1)) - sabs((ts <<< 3) - (one_s <<< 2));

	always_comb begin
		ctrl.kind = KIND_DIRECT;
		ctrl.sel  = DIV_SAW;
		ctrl.neg  = 1'b0;
		n         = '0;
		direct    = '0;
		case (inst_t'(instrument))
			WAVE_TRIANGLE: begin
				direct = VW'(tri_r);
			end
			WAVE_TILT_SAW: begin
				ctrl.kind = KIND_TILT;
				if (64'(t) < KNEE64) begin
					ctrl.sel = DIV_KNEE;
					n        = NW'(t);
				end else begin
					ctrl.sel = DIV_KNEE_C;
					n        = NW'(one_s - ts);
				end
			end
			WAVE_SAW: begin
				ctrl.kind = KIND_SIGNED;
				ctrl.sel  = DIV_SAW;
				ctrl.neg  = t[F-1];
				n         = t[F-1] ? NW'(one_s - ts) : NW'(t);
			end
			WAVE_SQUARE: begin
				direct = t[F-1] ? -quart_v : quart_v;
			end
			WAVE_PULSE: begin
				direct = (64'(t) < THIRD64) ? quart_v : -quart_v;
			end
			WAVE_ORGAN: begin
				ctrl.kind = KIND_SIGNED;
				ctrl.sel  = DIV_NINE;
				ctrl.neg  = org_r < 0;
				n         = NW'(sabs(org_r));
			end
			WAVE_PHASER: begin
				ctrl.kind = KIND_SIGNED;
				ctrl.sel  = DIV_SIX;
				ctrl.neg  = ph_r < 0;
				n         = NW'(sabs(ph_r));
			end
			default: begin
				direct = '0;
			end
		endcase
	end

endmodule

// ----- hdl/cwg_divide.sv -----
module cwg_divide
	import cwg_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en_s3,
	input  logic                        en_s4,
	input  ctrl_t                       ctrl_s2,
	input  logic [FRAC_BITS+2:0]        n_s2,
	input  logic signed [FRAC_BITS+3:0] direct_s2,
	output logic signed [SAMPLE_W-1:0]  sample
);

	localparam int F    = FRAC_BITS;
	localparam int NW   = F + 3;
	localparam int RW   = F + 8;
	localparam int L    = F + 3;
	localparam int QW   = F + 2;
	localparam int DW   = F + 1;
	localparam int MW   = NW + RW;
	localparam int NUMW = 2 * F + 3;
	localparam int VW   = F + 4;
	localparam int XW   = (VW > SAMPLE_W) ? VW : SAMPLE_W;
	localparam logic [63:0] ONE64    = 64'd1 << F;
	localparam logic [63:0] KNEE64   = (64'd9 << F) / 64'd10;
	localparam logic [63:0] KNEEC64  = ONE64 - KNEE64;
	localparam logic [63:0] SAWK64   = (64'd653 << F) / 64'd1000;
	localparam logic [63:0] R_KNEE   = (64'd1 << (2 * F + 4)) / KNEE64;
	localparam logic [63:0] R_KNEE_C = (64'd1 << (2 * F + 4)) / KNEEC64;
	localparam logic [63:0] R_NINE   = (64'd1 << L) / 64'd9;
	localparam logic [63:0] R_SIX    = (64'd1 << L) / 64'd6;
	localparam logic [63:0] R_SAW    = SAWK64 << 3;

	// Reciprocals are rounded down, so the first quotient is exact or one short.
	function automatic logic [RW-1:0] recip(input div_t s);
		case (s)
			DIV_KNEE:   return RW'(R_KNEE);
			DIV_KNEE_C: return RW'(R_KNEE_C);
			DIV_NINE:   return RW'(R_NINE);
			DIV_SIX:    return RW'(R_SIX);
			default:    return RW'(R_SAW);
		endcase
	endfunction

	function automatic logic [DW-1:0] divisor(input div_t s);
		case (s)
			DIV_KNEE:   return DW'(KNEE64);
			DIV_KNEE_C: return DW'(KNEEC64);
			DIV_NINE:   return DW'(9);
			DIV_SIX:    return DW'(6);
			default:    return DW'(1);
		endcase
	endfunction

	logic [MW-1:0]              prod;
	ctrl_t                      ctrl_s3;
	logic [NW-1:0]              n_s3;
	logic [QW-1:0]              q0_s3;
	logic signed [VW-1:0]       direct_s3;
	logic [NUMW-1:0]            num;
	logic [NUMW-1:0]            qd;
	logic [NUMW-1:0]            rem;
	logic                       bump;
	logic [QW-1:0]              q;
	logic signed [VW-1:0]       q_s;
	logic signed [VW-1:0]       val;
	logic signed [XW-1:0]       ext;
	logic signed [SAMPLE_W-1:0] sample_s4;

	assign prod = MW'(n_s2) * MW'(recip(ctrl_s2.sel));

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ctrl_s3   <= ctrl_s2;
			n_s3      <= n_s2;
			q0_s3     <= prod[L+QW-1:L];
			direct_s3 <= direct_s2;
		end
	end

	// The tilted saw divides its numerator shifted left by FRAC_BITS + 1 bits.
	always_comb begin
		if (ctrl_s3.sel == DIV_KNEE || ctrl_s3.sel == DIV_KNEE_C) begin
			num = NUMW'(n_s3) << (F + 1);
		end else begin
			num = NUMW'(n_s3);
		end
	end

	assign qd   = NUMW'(q0_s3) * NUMW'(divisor(ctrl_s3.sel));
	assign rem  = num - qd;
	assign bump = (ctrl_s3.sel != DIV_SAW) && (rem >= NUMW'(divisor(ctrl_s3.sel)));
	assign q    = q0_s3 + QW'(bump);
	assign q_s  = $signed(VW'(q));

	always_comb begin
		case (ctrl_s3.kind)
			KIND_TILT:   val = (q_s - $signed(VW'(ONE64))) >>> 1;
			KIND_SIGNED: val = ctrl_s3.neg ? -q_s : q_s;
			default:     val = direct_s3;
		endcase
	end

	assign ext = XW'(val);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sample_s4 <= ext[SAMPLE_W-1:0];
		end
	end

	assign sample = sample_s4;

endmodule

// ----- dv/cwg_sample_checker.sv -----
`timescale 1ns / 100ps

module cwg_sample_checker
	import cwg_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic                        item_ready,
	input  logic [INST_W-1:0]           instrument,
	input  logic signed [PHASE_W-1:0]   phase,
	input  logic                        sample_valid,
	input  logic                        sample_ready,
	input  logic signed [SAMPLE_W-1:0]  sample,
	output int                          fail_count,
	output int                          pending
);

	localparam longint ONE   = longint'(1) << FRAC_BITS;
	localparam longint MASK  = ONE - 1;
	localparam longint HALF  = ONE / 2;
	localparam longint QUART = ONE / 4;
	localparam longint THIRD = (longint'(3333) << FRAC_BITS) / 10000;
	localparam longint KNEE  = (longint'(9) << FRAC_BITS) / 10;
	localparam longint SAWK  = (longint'(653) << FRAC_BITS) / 1000;

	typedef struct {
		inst_t                inst;
		logic [PHASE_W-1:0]   phase;
		logic [SAMPLE_W-1:0]  sample;
	} sample_due_t;

	sample_due_t samples_due[$];
	int n_errors = 0;

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Expected sample for one beat; the shapes work on the fractional part t, the phaser also on f.
	function automatic logic [SAMPLE_W-1:0] shape_sample(input inst_t inst,
			input logic signed [PHASE_W-1:0] ph);
		longint p, t, f, k, hk, u, r, s;
		p = longint'(ph);
		t = p & MASK;
		case (inst)
			WAVE_TRIANGLE: begin
				s = (mag(4 * t - 2 * ONE) - ONE) >>> 1;
			end
			WAVE_TILT_SAW: begin
				if (t < KNEE)
					r = (2 * t * ONE) / KNEE - ONE;
				else
					r = (2 * (ONE - t) * ONE) / (ONE - KNEE) - ONE;
				s = r >>> 1;
			end
			WAVE_SAW: begin
				s = (SAWK * ((t < HALF) ? t : t - ONE)) / ONE;
			end
			WAVE_SQUARE: begin
				s = (t < HALF) ? QUART : -QUART;
			end
			WAVE_PULSE: begin
				s = (t < THIRD) ? QUART : -QUART;
			end
			WAVE_ORGAN: begin
				if (t < HALF)
					r = 3 * ONE - mag(24 * t - 6 * ONE);
				else
					r = ONE - mag(16 * t - 12 * ONE);
				s = r / 9;
			end
			WAVE_PHASER: begin
				// The modulator triangle comes from the phase shifted right by seven.
				f  = (p >>> 7) & MASK;
				k  = mag(2 * f - ONE);
				hk = (HALF * k) / ONE;
				u  = (t + hk) & MASK;
				r  = mag(4 * u - 2 * ONE) - mag(8 * t - 4 * ONE);
				s  = r / 6;
			end
			default: begin
				s = 0;
			end
		endcase
		return s[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk) begin : compare
		sample_due_t due;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				if (samples_due.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: sample %h arrived with no beat outstanding",
							$realtime, sample);
				end else begin
					due = samples_due.pop_front();
					if (sample !== due.sample) begin
						n_errors++;
						if (n_errors <= 10)
							$display("%0t: %s phase %h: expected sample %h, got %h",
								$realtime, due.inst.name(), due.phase, due.sample, sample);
					end
				end
			end
			if (item_valid && item_ready)
				samples_due.push_back('{inst_t'(instrument), phase,
					shape_sample(inst_t'(instrument), phase)});
		end
		fail_count <= n_errors;
		pending    <= samples_due.size();
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import cwg_pkg::*;

	localparam int     FRAC_BITS   = 16;
	localparam longint ONE         = longint'(1) << FRAC_BITS;
	localparam longint MASK        = ONE - 1;
	localparam longint HALF        = ONE / 2;
	localparam longint THIRD       = (longint'(3333) << FRAC_BITS) / 10000;
	localparam longint KNEE        = (longint'(9) << FRAC_BITS) / 10;
	localparam int     PHASE_BEATS = 335;
	localparam int     HOLD_CYCLES = 60;
	localparam int     IDLE_LIMIT  = 2000;

	logic                        clk;
	logic                        arst_n;
	logic                        item_valid;
	logic                        item_ready;
	inst_t                       instrument;
	logic signed [PHASE_W-1:0]   phase;
	logic                        sample_valid;
	logic                        sample_ready;
	logic signed [SAMPLE_W-1:0]  sample;

	int   fail_count;
	int   pending;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic hold_req = 1'b0;
	int   idle_cycles = 0;

	chiptune_waveform_generator #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.instrument   (instrument),
		.phase        (phase),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample)
	);

	cwg_sample_checker #(
		.FRAC_BITS(FRAC_BITS)
	) u_sample_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.instrument   (instrument),
		.phase        (phase),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one beat, with random idle cycles first, and return at the edge
	// where it is taken.
	task automatic send_beat(input inst_t inst, input logic [PHASE_W-1:0] ph);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		instrument <= inst;
		phase      <= ph;
		do @(posedge clk); while (!item_ready);
	endtask

	// Mostly fully random phases; the rest put t right around a shape's knee.
	function automatic logic [PHASE_W-1:0] pick_phase();
		longint knot, frac;
		logic [PHASE_W-1:0] upper;
		upper = $urandom;
		if ($urandom_range(0, 9) < 7)
			return upper;
		case ($urandom_range(0, 4))
			0: knot = 0;
			1: knot = HALF;
			2: knot = KNEE;
			3: knot = THIRD;
			default: knot = ONE;
		endcase
		frac = (knot + longint'($urandom_range(0, 4)) - 2) & MASK;
		return (upper & ~PHASE_W'(MASK)) | PHASE_W'(frac);
	endfunction

	initial begin : receiver
		int hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		sample_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				sample_ready <= 1'b0;
			end else begin
				sample_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (sample_valid && sample_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		instrument <= WAVE_TRIANGLE;
		phase      <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: both phase extremes for every instrument, then the knees.
		for (int i = 0; i < 8; i++) begin
			send_beat(inst_t'(i), 32'h0000_0000);
			send_beat(inst_t'(i), 32'hFFFF_FFFF);
		end
		send_beat(WAVE_TILT_SAW, PHASE_W'(KNEE - 1));
		send_beat(WAVE_TILT_SAW, 32'hC000_0000 | PHASE_W'(KNEE));
		send_beat(WAVE_SAW, 32'h0001_0000 | PHASE_W'(HALF));
		send_beat(WAVE_SQUARE, PHASE_W'(HALF - 1));
		send_beat(WAVE_PULSE, PHASE_W'(THIRD - 1));
		send_beat(WAVE_PULSE, 32'h8000_0000 | PHASE_W'(THIRD));
		send_beat(WAVE_ORGAN, PHASE_W'(HALF));
		send_beat(WAVE_PHASER, 32'h8000_0000);
		send_beat(WAVE_PHASER, 32'h7FFF_FFFF);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			if (p == 0) begin
				// The receiver holds off while beats keep coming, so the pipeline
				// fills and backs up into the input.
				hold_req = 1'b1;
				for (int n = 0; n < 12; n++)
					send_beat(inst_t'($urandom_range(0, 7)), pick_phase());
			end
			for (int n = 0; n < PHASE_BEATS; n++)
				send_beat(inst_t'($urandom_range(0, 7)), pick_phase());
		end
		item_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- chiptune_waveform_generator.f -----
hdl/cwg_pkg.sv
hdl/cwg_shape.sv
hdl/cwg_divide.sv
hdl/chiptune_waveform_generator.sv
dv/cwg_sample_checker.sv
dv/tb_top.sv
